@@ sv/schaffer_f6_fitness_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Schaffer F6 fitness unit assertion macros
// Concurrent checks sampled on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SCHAFFER_F6_FITNESS_UNIT_ASSERT_SVH
`define SCHAFFER_F6_FITNESS_UNIT_ASSERT_SVH

// check that cons holds in the same cycle as ante
`define SF6_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fitness unit check failed");

// check that cons holds in the cycle after ante
`define SF6_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fitness unit check failed");

`endif

@@ sv/sf6_pkg.sv @@
// ---------------------------------------------------------------------------
// Schaffer F6 fitness package
// Fixed formats, angle constants and series tables shared by the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sf6_pkg;

  localparam int GeneBits       = 22;
  localparam int ChromBits      = 44;
  localparam int ResultFracBits = 16;
  localparam int FitBits        = ResultFracBits + 1;
  localparam int MagBits        = 31;
  localparam int SqBits         = 2 * MagBits;
  localparam int R2Bits         = SqBits + 1;
  localparam int RootBits       = 32;
  localparam int AngBits        = 40;
  localparam int PiSteps        = 7;
  localparam int DenBits        = 31;
  localparam int NumTerms       = 7;
  localparam int DivNumBits     = 56;
  localparam int QuoBits        = 32;

  localparam logic [21:0] GeneDen    = 22'h3FFFFF;
  localparam logic [20:0] GeneRound  = 21'h1FFFFF;
  localparam logic [31:0] GeneOffset = 32'h6400_0000;

  localparam logic [33:0] PiQ32        = 34'h3243F6A89;
  localparam logic [32:0] HalfPiQ32    = 33'h1921FB544;
  localparam logic [31:0] QuarterPiQ32 = 32'hC90FDAA2;
  localparam logic [32:0] OneQ32       = 33'h1_0000_0000;
  localparam logic [31:0] HalfQ32      = 32'h8000_0000;
  localparam logic [24:0] OneQ24       = 25'h100_0000;

  localparam logic [63:0] DenRound = 64'd8388608000;
  localparam logic [30:0] DenRecip = 31'd1099511627;
  localparam logic [9:0]  DenDiv   = 10'd1000;

  localparam logic [7:0] TermDiv [NumTerms] = '{
    8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210
  };

  localparam logic [29:0] TermRecip [NumTerms] = '{
    30'd715827882, 30'd214748364, 30'd102261126, 30'd59652323,
    30'd39045157, 30'd27531841, 30'd20452225
  };

  typedef struct packed {
    logic               cos_br;
    logic [DenBits-1:0] den;
    logic [31:0]        u2;
    logic [33:0]        acc;
  } sin_ctx_t;

endpackage

`default_nettype wire

@@ sv/sf6_div.sv @@
// ---------------------------------------------------------------------------
// Schaffer F6 pipelined divider
// Restoring division, one quotient bit per register stage, with sideband.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sf6_div #(
  parameter int NUM_W  = 56,
  parameter int DEN_W  = 31,
  parameter int QUO_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [DEN_W-1:0]  den_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int CMP_W = (DEN_W + QUO_W > NUM_W) ? DEN_W + QUO_W : NUM_W;

  logic              vld_q  [QUO_W];
  logic [NUM_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];
  logic [NUM_W-1:0]  rem_d  [QUO_W];
  logic [QUO_W-1:0]  quo_d  [QUO_W];

  always_comb begin : p_next
    logic [NUM_W-1:0] rem_p;
    logic [QUO_W-1:0] quo_p;
    logic [DEN_W-1:0] den_p;
    logic [CMP_W-1:0] trial;
    for (int i = 0; i < QUO_W; i++) begin
      if (i == 0) begin
        rem_p = num_i;
        quo_p = '0;
        den_p = den_i;
      end else begin
        rem_p = rem_q[i-1];
        quo_p = quo_q[i-1];
        den_p = den_q[i-1];
      end
      trial = CMP_W'(den_p) << (QUO_W - 1 - i);
      if (CMP_W'(rem_p) >= trial) begin
        rem_d[i] = NUM_W'(CMP_W'(rem_p) - trial);
        quo_d[i] = quo_p | (QUO_W'(1) << (QUO_W - 1 - i));
      end else begin
        rem_d[i] = rem_p;
        quo_d[i] = quo_p;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUO_W; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < QUO_W; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int i = 1; i < QUO_W; i++) begin
        den_q[i]  <= den_q[i-1];
        side_q[i] <= side_q[i-1];
      end
      for (int i = 0; i < QUO_W; i++) begin
        rem_q[i] <= rem_d[i];
        quo_q[i] <= quo_d[i];
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign den_o   = den_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

`default_nettype wire

@@ sv/schaffer_f6_fitness_unit.sv @@
// ---------------------------------------------------------------------------
// Schaffer F6 fitness unit
// Decodes two genes, evaluates the maximisation form of Schaffer F6 in fixed
// point and returns the fitness scaled by 2^16, one word per clock unless stalled.
// ---------------------------------------------------------------------------
//   channel   valid     stall     payload
//   input     valid_i   stall_o   chromosome_i [43:0]
//   output    valid_o   stall_i   fitness_o    [16:0]
//
// One word enters per clock while stall_o is low; a word passes 135 register
// stages, from the gene decode registers to the output register behind valid_o.
// The stage count is set by the bit-per-stage square root and the two
// bit-per-stage dividers (96 of the 135 stages).
// Reset clears all valid bits; datapath registers are not reset.
// A stall on the output fills a skid register; stall_o is that register's
// valid bit, so the input side never sees stall_i combinationally.
`timescale 1ns / 1ps
`default_nettype none
`include "schaffer_f6_fitness_unit_assert.svh"

module schaffer_f6_fitness_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [43:0] chromosome_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [16:0] fitness_o
);

  localparam int NT = sf6_pkg::NumTerms;
  localparam int RB = sf6_pkg::RootBits;
  localparam int PS = sf6_pkg::PiSteps;

  function automatic logic [53:0] gene_num(input logic [21:0] g);
    return {30'(g) * 30'd200, 24'd0} + 54'(sf6_pkg::GeneRound);
  endfunction

  function automatic logic [32:0] gene_est(input logic [53:0] n);
    return 33'(n >> 22) + 33'(n >> 44);
  endfunction

  function automatic logic [30:0] gene_mag(input logic [53:0] n, input logic [32:0] e);
    logic [55:0] rem;
    logic [31:0] v;
    rem = 56'(n) + 56'(e) - (56'(e) << 22);
    if (rem >= {33'd0, sf6_pkg::GeneDen, 1'b0}) v = 32'(e) + 32'd2;
    else if (rem >= 56'(sf6_pkg::GeneDen)) v = 32'(e) + 32'd1;
    else v = 32'(e);
    if (v >= sf6_pkg::GeneOffset) return 31'(v - sf6_pkg::GeneOffset);
    else return 31'(sf6_pkg::GeneOffset - v);
  endfunction

  logic        adv;
  logic        out_vld_q, skid_vld_q;
  logic [16:0] out_q, skid_q;

  assign adv     = ~skid_vld_q;
  assign stall_o = skid_vld_q;

  // gene decode
  logic        g1_vld_q, g2_vld_q;
  logic [53:0] g1_nx_q, g1_ny_q;
  logic [32:0] g1_ex_q, g1_ey_q;
  logic [30:0] g2_ax_q, g2_ay_q;
  // squares and radius
  logic        pw_vld_q, r2_vld_q;
  logic [61:0] pw_x_q, pw_y_q;
  logic [62:0] r2_q;
  // 1 + r2/1000
  logic        d1_vld_q, d2_vld_q, d3_vld_q;
  logic [62:0] d1_r2_q, d2_r2_q, d3_r2_q;
  logic [39:0] d1_x_q, d2_x_q;
  logic [50:0] d1_ph_q, d1_pl_q;
  logic [30:0] d2_qe_q;
  logic [30:0] d3_den_q;
  // square root
  logic        rt_vld_q  [RB];
  logic [63:0] rt_rem_q  [RB];
  logic [31:0] rt_root_q [RB];
  logic [30:0] rt_den_q  [RB];
  logic [63:0] rt_rem_d  [RB];
  logic [31:0] rt_root_d [RB];
  // angle reduction
  logic        md_vld_q [PS];
  logic [39:0] md_t_q   [PS];
  logic [30:0] md_den_q [PS];
  logic [39:0] md_t_d   [PS];
  logic        fd_vld_q;
  logic [31:0] fd_u_q;
  logic        fd_cos_q;
  logic [30:0] fd_den_q;
  logic [33:0] fd_t1;
  logic        fd_cos_d;
  logic [31:0] fd_u_d;
  // sine series
  logic              su_vld_q;
  logic [31:0]       su_term_q;
  sf6_pkg::sin_ctx_t su_ctx_q;
  logic              ta_vld_q [NT];
  logic [31:0]       ta_p_q   [NT];
  sf6_pkg::sin_ctx_t ta_ctx_q [NT];
  logic              tb_vld_q [NT];
  logic [31:0]       tb_p_q   [NT];
  logic [61:0]       tb_pm_q  [NT];
  sf6_pkg::sin_ctx_t tb_ctx_q [NT];
  logic              tc_vld_q  [NT];
  logic [31:0]       tc_term_q [NT];
  sf6_pkg::sin_ctx_t tc_ctx_q  [NT];
  logic [31:0]       ta_p_d    [NT];
  logic [31:0]       tc_term_d [NT];
  logic [33:0]       tc_acc_d  [NT];
  // sin^2 and quotients
  logic        s2_vld_q;
  logic [32:0] s2_q;
  logic [30:0] s2_den_q;
  logic [32:0] s2_d;
  logic        mg_below;
  logic [31:0] mg_mag;
  logic        dv1_vld, dv2_vld;
  logic [31:0] dv1_quo, dv2_quo;
  logic [30:0] dv1_den, dv2_den;
  logic        dv1_below, dv2_below;
  logic [16:0] tail_res;

  always_comb begin : p_fold
    logic [33:0] t;
    t = 34'(md_t_q[PS-1]);
    fd_t1 = (t > 34'(sf6_pkg::HalfPiQ32)) ? sf6_pkg::PiQ32 - t : t;
    fd_cos_d = fd_t1 > 34'(sf6_pkg::QuarterPiQ32);
    if (fd_cos_d) begin
      fd_u_d = (fd_t1 >= 34'(sf6_pkg::HalfPiQ32)) ? 32'd0
             : 32'(34'(sf6_pkg::HalfPiQ32) - fd_t1);
    end else begin
      fd_u_d = 32'(fd_t1);
    end
  end

  always_comb begin : p_root
    logic [63:0] rem_p;
    logic [31:0] root_p;
    logic [64:0] trial;
    for (int i = 0; i < RB; i++) begin
      if (i == 0) begin
        rem_p  = 64'(d3_r2_q);
        root_p = '0;
      end else begin
        rem_p  = rt_rem_q[i-1];
        root_p = rt_root_q[i-1];
      end
      trial = (65'(root_p) << (RB - i)) + (65'(1) << (2 * (RB - 1 - i)));
      if (65'(rem_p) >= trial) begin
        rt_rem_d[i]  = 64'(65'(rem_p) - trial);
        rt_root_d[i] = root_p | (32'(1) << (RB - 1 - i));
      end else begin
        rt_rem_d[i]  = rem_p;
        rt_root_d[i] = root_p;
      end
    end
  end

  always_comb begin : p_mod
    logic [39:0] t_p;
    logic [40:0] trial;
    for (int i = 0; i < PS; i++) begin
      t_p   = (i == 0) ? {rt_root_q[RB-1], 8'd0} : md_t_q[i-1];
      trial = 41'(sf6_pkg::PiQ32) << (PS - 1 - i);
      md_t_d[i] = (41'(t_p) >= trial) ? 40'(41'(t_p) - trial) : t_p;
    end
  end

  always_comb begin : p_series
    logic [31:0] term_p;
    logic [31:0] u2_p;
    logic [31:0] qe;
    logic [39:0] rem;
    for (int k = 0; k < NT; k++) begin
      term_p = (k == 0) ? su_term_q : tc_term_q[k-1];
      u2_p   = (k == 0) ? su_ctx_q.u2 : tc_ctx_q[k-1].u2;
      ta_p_d[k] = 32'((64'(term_p) * 64'(u2_p)) >> 32);
      qe  = 32'(tb_pm_q[k] >> 32);
      rem = 40'(tb_p_q[k]) - 40'(qe) * 40'(sf6_pkg::TermDiv[k]);
      tc_term_d[k] = (rem >= 40'(sf6_pkg::TermDiv[k])) ? qe + 32'd1 : qe;
      if ((k % 2) == 0) tc_acc_d[k] = tb_ctx_q[k].acc - 34'(tc_term_d[k]);
      else              tc_acc_d[k] = tb_ctx_q[k].acc + 34'(tc_term_d[k]);
    end
  end

  always_comb begin : p_square
    logic [33:0] acc;
    logic [31:0] c;
    logic [31:0] sq;
    acc = tc_ctx_q[NT-1].acc;
    priority if (acc[33]) c = 32'd0;
    else if (acc[32])     c = 32'hFFFF_FFFF;
    else                  c = acc[31:0];
    sq = 32'((64'(c) * 64'(c)) >> 32);
    s2_d = tc_ctx_q[NT-1].cos_br ? sf6_pkg::OneQ32 - 33'(sq) : 33'(sq);
  end

  assign mg_below = s2_q < 33'(sf6_pkg::HalfQ32);
  assign mg_mag   = mg_below ? 32'(33'(sf6_pkg::HalfQ32) - s2_q)
                             : 32'(s2_q - 33'(sf6_pkg::HalfQ32));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_vld_q <= 1'b0;
      g2_vld_q <= 1'b0;
      pw_vld_q <= 1'b0;
      r2_vld_q <= 1'b0;
      d1_vld_q <= 1'b0;
      d2_vld_q <= 1'b0;
      d3_vld_q <= 1'b0;
      fd_vld_q <= 1'b0;
      su_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      for (int i = 0; i < RB; i++) rt_vld_q[i] <= 1'b0;
      for (int i = 0; i < PS; i++) md_vld_q[i] <= 1'b0;
      for (int k = 0; k < NT; k++) begin
        ta_vld_q[k] <= 1'b0;
        tb_vld_q[k] <= 1'b0;
        tc_vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      g1_vld_q <= valid_i;
      g2_vld_q <= g1_vld_q;
      pw_vld_q <= g2_vld_q;
      r2_vld_q <= pw_vld_q;
      d1_vld_q <= r2_vld_q;
      d2_vld_q <= d1_vld_q;
      d3_vld_q <= d2_vld_q;
      rt_vld_q[0] <= d3_vld_q;
      for (int i = 1; i < RB; i++) rt_vld_q[i] <= rt_vld_q[i-1];
      md_vld_q[0] <= rt_vld_q[RB-1];
      for (int i = 1; i < PS; i++) md_vld_q[i] <= md_vld_q[i-1];
      fd_vld_q <= md_vld_q[PS-1];
      su_vld_q <= fd_vld_q;
      for (int k = 0; k < NT; k++) begin
        ta_vld_q[k] <= (k == 0) ? su_vld_q : tc_vld_q[k-1];
        tb_vld_q[k] <= ta_vld_q[k];
        tc_vld_q[k] <= tb_vld_q[k];
      end
      s2_vld_q <= tc_vld_q[NT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g1_nx_q <= gene_num(chromosome_i[43:22]);
      g1_ny_q <= gene_num(chromosome_i[21:0]);
      g1_ex_q <= gene_est(gene_num(chromosome_i[43:22]));
      g1_ey_q <= gene_est(gene_num(chromosome_i[21:0]));
      g2_ax_q <= gene_mag(g1_nx_q, g1_ex_q);
      g2_ay_q <= gene_mag(g1_ny_q, g1_ey_q);
      pw_x_q  <= 62'(g2_ax_q) * 62'(g2_ax_q);
      pw_y_q  <= 62'(g2_ay_q) * 62'(g2_ay_q);
      r2_q    <= 63'(pw_x_q) + 63'(pw_y_q);

      d1_r2_q <= r2_q;
      d1_x_q  <= 40'((64'(r2_q) + sf6_pkg::DenRound) >> 24);
      d1_ph_q <= 51'(40'((64'(r2_q) + sf6_pkg::DenRound) >> 24) >> 20)
               * 51'(sf6_pkg::DenRecip);
      d1_pl_q <= 51'(20'((64'(r2_q) + sf6_pkg::DenRound) >> 24))
               * 51'(sf6_pkg::DenRecip);
      d2_r2_q <= d1_r2_q;
      d2_x_q  <= d1_x_q;
      d2_qe_q <= 31'(((72'(d1_ph_q) << 20) + 72'(d1_pl_q)) >> 40);
      d3_r2_q <= d2_r2_q;
      d3_den_q <= 31'(sf6_pkg::OneQ24) + d2_qe_q
                + (((41'(d2_x_q) - 41'(d2_qe_q) * 41'(sf6_pkg::DenDiv))
                    >= 41'(sf6_pkg::DenDiv)) ? 31'd1 : 31'd0);

      rt_den_q[0] <= d3_den_q;
      for (int i = 1; i < RB; i++) rt_den_q[i] <= rt_den_q[i-1];
      for (int i = 0; i < RB; i++) begin
        rt_rem_q[i]  <= rt_rem_d[i];
        rt_root_q[i] <= rt_root_d[i];
      end

      md_den_q[0] <= rt_den_q[RB-1];
      for (int i = 1; i < PS; i++) md_den_q[i] <= md_den_q[i-1];
      for (int i = 0; i < PS; i++) md_t_q[i] <= md_t_d[i];

      fd_u_q   <= fd_u_d;
      fd_cos_q <= fd_cos_d;
      fd_den_q <= md_den_q[PS-1];

      su_term_q       <= fd_u_q;
      su_ctx_q.cos_br <= fd_cos_q;
      su_ctx_q.den    <= fd_den_q;
      su_ctx_q.u2     <= 32'((64'(fd_u_q) * 64'(fd_u_q)) >> 32);
      su_ctx_q.acc    <= 34'(fd_u_q);

      for (int k = 0; k < NT; k++) begin
        ta_p_q[k]   <= ta_p_d[k];
        ta_ctx_q[k] <= (k == 0) ? su_ctx_q : tc_ctx_q[k-1];
        tb_p_q[k]   <= ta_p_q[k];
        tb_pm_q[k]  <= 62'(ta_p_q[k]) * 62'(sf6_pkg::TermRecip[k]);
        tb_ctx_q[k] <= ta_ctx_q[k];
        tc_term_q[k]       <= tc_term_d[k];
        tc_ctx_q[k].cos_br <= tb_ctx_q[k].cos_br;
        tc_ctx_q[k].den    <= tb_ctx_q[k].den;
        tc_ctx_q[k].u2     <= tb_ctx_q[k].u2;
        tc_ctx_q[k].acc    <= tc_acc_d[k];
      end

      s2_q     <= s2_d;
      s2_den_q <= tc_ctx_q[NT-1].den;
    end
  end

  sf6_div #(
    .NUM_W (56),
    .DEN_W (31),
    .QUO_W (32),
    .SIDE_W(1)
  ) u_div_first (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(s2_vld_q),
    .num_i  ({mg_mag, 24'd0}),
    .den_i  (s2_den_q),
    .side_i (mg_below),
    .valid_o(dv1_vld),
    .quo_o  (dv1_quo),
    .den_o  (dv1_den),
    .side_o (dv1_below)
  );

  sf6_div #(
    .NUM_W (56),
    .DEN_W (31),
    .QUO_W (32),
    .SIDE_W(1)
  ) u_div_second (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(dv1_vld),
    .num_i  ({dv1_quo, 24'd0}),
    .den_i  (dv1_den),
    .side_i (dv1_below),
    .valid_o(dv2_vld),
    .quo_o  (dv2_quo),
    .den_o  (dv2_den),
    .side_o (dv2_below)
  );

  always_comb begin : p_result
    logic [33:0] fit;
    logic [32:0] fit_sat;
    if (dv2_below) fit = 34'(sf6_pkg::HalfQ32) + 34'(dv2_quo);
    else           fit = 34'(sf6_pkg::HalfQ32) - 34'(dv2_quo);
    priority if (!dv2_below && (dv2_quo > sf6_pkg::HalfQ32)) fit_sat = 33'd0;
    else if (fit > 34'(sf6_pkg::OneQ32))                     fit_sat = sf6_pkg::OneQ32;
    else                                                     fit_sat = fit[32:0];
    tail_res = 17'((34'(fit_sat) + (34'(1) << (31 - sf6_pkg::ResultFracBits)))
                   >> (32 - sf6_pkg::ResultFracBits));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (adv) begin
      if (!out_vld_q || !stall_i) out_vld_q <= dv2_vld;
      else if (dv2_vld)           skid_vld_q <= 1'b1;
    end else if (!stall_i) begin
      out_vld_q  <= 1'b1;
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (!out_vld_q || !stall_i) out_q <= tail_res;
      else                        skid_q <= tail_res;
    end else if (!stall_i) begin
      out_q <= skid_q;
    end
  end

  assign valid_o   = out_vld_q;
  assign fitness_o = out_q;

  `SF6_ASSERT_NOW(a_skid_behind_out, skid_vld_q, out_vld_q)
  `SF6_ASSERT_NOW(a_fitness_range, out_vld_q, fitness_o <= 17'd65536)
  `SF6_ASSERT_NEXT(a_skid_catches, adv && out_vld_q && stall_i && dv2_vld, skid_vld_q)
  `SF6_ASSERT_NOW(a_den_floor, dv2_vld, dv2_den >= 31'(sf6_pkg::OneQ24))

endmodule

`default_nettype wire

@@ tb/schaffer_f6_fitness_unit_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Schaffer F6 fitness checker
// Watches both channels, predicts the fitness of every accepted chromosome
// in fixed point and compares each returned word with the oldest prediction.
// ---------------------------------------------------------------------------
module schaffer_f6_fitness_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic [43:0] chromosome_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic [16:0] fitness_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  logic [16:0] fitness_q[$];

  function automatic logic [63:0] gene_magnitude(input logic [63:0] g);
    logic [63:0] den, n, q, rem, frac, v, off;
    den  = (64'd1 << sf6_pkg::GeneBits) - 1;
    n    = g * 64'd200;
    q    = n / den;
    rem  = n % den;
    frac = ((rem << 24) + den / 2) / den;
    v    = (q << 24) + frac;
    off  = 64'd100 << 24;
    return (v >= off) ? v - off : off - v;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] sine_series(input logic [63:0] u);
    logic [63:0]        u2, term;
    logic signed [63:0] s;
    logic               neg;
    u2   = (u * u) >> 32;
    term = u;
    s    = u;
    neg  = 1'b1;
    for (int n = 3; n <= 15; n += 2) begin
      term = ((term * u2) >> 32) / ((n - 1) * n);
      if (neg) s = s - $signed(term);
      else s = s + $signed(term);
      neg = !neg;
    end
    if (s < 0) s = 0;
    if (s >= $signed(64'd1 << 32)) s = (64'd1 << 32) - 1;
    return s;
  endfunction

  function automatic logic [16:0] predict_fitness(input logic [43:0] chrom);
    logic [63:0]        ax, ay, r2, r, t, s2, d, mag, q, c, s, u, res;
    logic [63:0]        pi_w, hpi_w, qpi_w, one_w, half_w;
    logic signed [63:0] fit;
    logic               below;
    pi_w   = sf6_pkg::PiQ32;
    hpi_w  = sf6_pkg::HalfPiQ32;
    qpi_w  = sf6_pkg::QuarterPiQ32;
    one_w  = sf6_pkg::OneQ32;
    half_w = sf6_pkg::HalfQ32;
    ax = gene_magnitude(chrom[43:22]);
    ay = gene_magnitude(chrom[21:0]);
    r2 = ax * ax + ay * ay;
    r  = root_floor(r2) << 8;
    t  = r - (r / pi_w) * pi_w;
    if (t > hpi_w) t = pi_w - t;
    if (t > qpi_w) begin
      u  = (t >= hpi_w) ? 64'd0 : hpi_w - t;
      c  = sine_series(u);
      s2 = one_w - ((c * c) >> 32);
    end else begin
      s  = sine_series(t);
      s2 = (s * s) >> 32;
    end
    d     = (64'd1 << 24) + (r2 + 64'd8388608000) / 64'd16777216000;
    below = s2 < half_w;
    mag   = below ? half_w - s2 : s2 - half_w;
    q     = (mag << 24) / d;
    q     = (q << 24) / d;
    fit   = below ? $signed(half_w + q) : $signed(half_w) - $signed(q);
    if (fit < 0) fit = 0;
    if (fit > $signed(one_w)) fit = one_w;
    res = (fit + (64'd1 << (31 - sf6_pkg::ResultFracBits)))
          >> (32 - sf6_pkg::ResultFracBits);
    return res[16:0];
  endfunction

  assign pending_o = fitness_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o <= 0;
      checked_o    <= 0;
    end else begin
      if (valid_i && !stall_o) fitness_q = {fitness_q, predict_fitness(chromosome_i)};
      if (valid_o && !stall_i) begin
        checked_o <= checked_o + 1;
        if (fitness_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected word: fitness %0d", fitness_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          if (fitness_q[0] !== fitness_o) begin
            if (fail_count_o < 10)
              $display("fitness mismatch: expected %0d actual %0d", fitness_q[0], fitness_o);
            fail_count_o <= fail_count_o + 1;
          end
          void'(fitness_q.pop_front());
        end
      end
    end
  end
endmodule

@@ tb/schaffer_f6_fitness_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Schaffer F6 fitness unit testbench
// Streams directed and random chromosomes with random gaps and stalls; the
// checker predicts every fitness word and counts mismatches.
// ---------------------------------------------------------------------------
module schaffer_f6_fitness_unit_tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [43:0] chromosome_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [16:0] fitness_o;
  int          fail_count, pending, checked;
  logic        calm_rx = 1'b0;
  int          rx_wait = 0;

  localparam logic [21:0] GeneMid = 22'h1FFFFF;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  schaffer_f6_fitness_unit uut (.*);

  schaffer_f6_fitness_unit_checker chk (
    .clk_i, .rst_ni, .valid_i, .stall_o, .chromosome_i, .valid_o, .stall_i,
    .fitness_o, .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // Idle for a drawn number of cycles, then hold the word until accepted.
  task automatic send_chromosome(input logic [43:0] chrom);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i      <= 1'b1;
    chromosome_i <= chrom;
    do @(posedge clk_i); while (stall_o);
  endtask

  // Sends back to back: valid stays high between words.
  task automatic send_burst(input int count);
    @(posedge clk_i);
    valid_i      <= 1'b1;
    chromosome_i <= 44'({$urandom(), $urandom()});
    for (int i = 0; i < count; i++) begin
      do @(posedge clk_i); while (stall_o);
      if (i < count - 1) chromosome_i <= 44'({$urandom(), $urandom()});
      else valid_i <= 1'b0;
    end
  endtask

  // Stall the output for a drawn number of cycles after each accepted word.
  always @(posedge clk_i) begin
    if (calm_rx) begin
      rx_wait = 0;
      stall_i <= 1'b0;
    end else if (valid_o && !stall_i) begin
      rx_wait = $urandom_range(0, 3);
      stall_i <= (rx_wait != 0);
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      stall_i <= (rx_wait != 0);
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [21:0] gx, gy;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_chromosome({22'h000000, 22'h000000});
    send_chromosome({22'h3FFFFF, 22'h3FFFFF});
    send_chromosome({22'h000000, 22'h3FFFFF});
    send_chromosome({22'h3FFFFF, 22'h000000});
    send_chromosome({GeneMid, GeneMid});
    send_chromosome({GeneMid + 22'd1, GeneMid + 22'd1});
    send_chromosome({GeneMid, GeneMid + 22'd1});
    send_chromosome({22'h2AAAAA, 22'h155555});
    send_chromosome({22'h155555, 22'h2AAAAA});
    send_chromosome({GeneMid + 22'd1000, GeneMid});
    send_chromosome({GeneMid - 22'd20000, GeneMid + 22'd33000});
    send_chromosome(44'hFFF_FFFF_FFFF);
    send_chromosome(44'h000_0000_0001);
    send_chromosome(44'h800_0000_0000);
    valid_i <= 1'b0;
    wait (pending == 0);
    calm_rx <= 1'b1;
    send_burst(40);
    calm_rx <= 1'b0;
    for (int i = 0; i < 1700; i++) begin
      if (i == 900) begin
        valid_i <= 1'b0;
        wait (pending == 0);
        send_burst(100);
      end
      case ($urandom_range(0, 3))
        0: begin
          gx = GeneMid + 22'($urandom_range(0, 60000)) - 22'd30000;
          gy = GeneMid + 22'($urandom_range(0, 60000)) - 22'd30000;
          send_chromosome({gx, gy});
        end
        1: send_chromosome({22'($urandom_range(0, 3)) ^ {22{$urandom_range(0, 1) == 1}},
                            22'($urandom())});
        default: send_chromosome(44'({$urandom(), $urandom()}));
      endcase
    end
    valid_i <= 1'b0;
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d fitness words: gene extremes, centre region, bursts", checked);
    $display("and random chromosomes with random gaps and output stalls.");
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
